// File: rtl/indexed_list_insert_delete_core_defines.svh
// assertion macros for the indexed list core
// used by indexed_list_insert_delete_core.sv; expects clk_i and rst_ni in scope
`ifndef INDEXED_LIST_INSERT_DELETE_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_DELETE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define ILID_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define ILID_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/ilid_pkg.sv
// shared types and constants for the indexed list core
// no dependencies
package ilid_pkg;

  // default list depth
  localparam int unsigned CAPACITY_DEF = 64;

  // fixed field widths
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned POS_MAG_W = POS_W - 1;
  localparam int unsigned FUNC_W  = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned ITEM_W  = 7;

  // request function codes
  typedef enum logic [FUNC_W-1:0] {
    FN_GET      = 3'd0,
    FN_INS_HEAD = 3'd1,
    FN_INS_TAIL = 3'd2,
    FN_INS_POS  = 3'd3,
    FN_DEL_POS  = 3'd4
  } ilid_func_e;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_DONE    = 2'd0,
    ST_BAD_POS = 2'd1,
    ST_FULL    = 2'd2
  } ilid_status_e;

  // shift command broadcast to every cell
  typedef struct packed {
    logic shift_up;    // open a slot at the op position, later entries move up
    logic shift_down;  // close the slot at the op position, later entries move down
  } ilid_ctrl_t;

endpackage

// File: rtl/ilid_cell.sv
// one storage cell of the indexed list: holds the entry at a fixed position
// depends on ilid_pkg
module ilid_cell import ilid_pkg::*; #(
  parameter int unsigned Idx  = 0,
  parameter int unsigned PosW = 7
) (
  input  logic              clk_i,
  input  ilid_ctrl_t        ctrl_i,
  input  logic [PosW-1:0]   op_pos_i,
  input  logic [DATA_W-1:0] new_value_i,
  input  logic [DATA_W-1:0] left_value_i,
  input  logic [DATA_W-1:0] right_value_i,
  output logic [DATA_W-1:0] value_o,
  output logic [DATA_W-1:0] read_value_o
);

  localparam logic [PosW-1:0] MyIdx = PosW'(Idx);

  logic [DATA_W-1:0] data_q, data_d;
  logic              above, at_pos;

  assign above  = MyIdx > op_pos_i;
  assign at_pos = MyIdx == op_pos_i;

  // next entry: take from a neighbor or the new value on a shift
  always_comb begin
    data_d = data_q;
    if (ctrl_i.shift_up) begin
      if (above) begin
        data_d = left_value_i;
      end else if (at_pos) begin
        data_d = new_value_i;
      end
    end else if (ctrl_i.shift_down) begin
      if (above || at_pos) begin
        data_d = right_value_i;
      end
    end
  end

  // entry storage, no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign value_o      = data_q;
  // masked read so the top level can or the cells together
  assign read_value_o = data_q & {DATA_W{at_pos}};

endmodule

// File: rtl/indexed_list_insert_delete_core.sv
// top level of the indexed list core: request decode, count and result registers
// depends on ilid_pkg, ilid_cell and indexed_list_insert_delete_core_defines.svh
//
//  channel   | direction | handshake          | payload
//  ----------+-----------+--------------------+----------------------------------
//  request   | in        | start_i, busy_o    | func_i, position_i, value_i
//  result    | out       | done_o (strobe)    | read_value_o, status_o, item_count_o
//
// a request is taken when start_i is high and busy_o is low; busy_o stays low,
// so one request can be taken every cycle.
// the row of cells shifts all entries in parallel at the accepting edge, and the
// result is shown with done_o for one cycle right after it.
// the result payload registers load at the same accepting edge as the parallel shift of the cells.
// reset clears the count and the result strobe; entry contents are left as is.
// the receiver cannot stall; done_o marks each result for one cycle only.
`include "indexed_list_insert_delete_core_defines.svh"

module indexed_list_insert_delete_core import ilid_pkg::*; #(
  parameter int unsigned Capacity = CAPACITY_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  output logic                     busy_o,
  input  logic [FUNC_W-1:0]        func_i,
  input  logic signed [POS_W-1:0]  position_i,
  input  logic signed [DATA_W-1:0] value_i,
  output logic                     done_o,
  output logic signed [DATA_W-1:0] read_value_o,
  output logic [STAT_W-1:0]        status_o,
  output logic [ITEM_W-1:0]        item_count_o
);

  localparam int unsigned CntW = $clog2(Capacity + 1);
  localparam int unsigned CmpW = (CntW > POS_MAG_W) ? CntW : POS_MAG_W;
  localparam logic [CntW-1:0] CapCnt = CntW'(Capacity);

  logic [CntW-1:0]   count_q, count_d;
  logic              done_q;
  logic [DATA_W-1:0] rd_q, rd_d;
  ilid_status_e      status_q, status_d;
  logic [ITEM_W-1:0] item_q;

  logic              accept;
  logic              pos_neg, in_range, full;
  logic [CmpW-1:0]   pos_mag, cnt_ext, op_pos;
  ilid_ctrl_t        ctrl;
  logic              want_ins;
  logic [DATA_W-1:0] cell_val [Capacity];
  logic [DATA_W-1:0] cell_rd  [Capacity];
  logic [DATA_W-1:0] read_data;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // position decode against the current count
  assign pos_neg  = position_i[POS_W-1];
  assign pos_mag  = CmpW'(position_i[POS_MAG_W-1:0]);
  assign cnt_ext  = CmpW'(count_q);
  assign in_range = !pos_neg && (pos_mag < cnt_ext);
  assign full     = count_q == CapCnt;

  // operation position for the shift and the read
  always_comb begin
    op_pos = pos_mag;
    case (ilid_func_e'(func_i))
      FN_INS_HEAD: op_pos = '0;
      FN_INS_TAIL: op_pos = cnt_ext;
      FN_INS_POS:  op_pos = pos_neg ? '0 : pos_mag;
      default:     op_pos = pos_mag;
    endcase
  end

  // or together the masked reads of all cells
  always_comb begin
    read_data = '0;
    for (int i = 0; i < Capacity; i++) begin
      read_data = read_data | cell_rd[i];
    end
  end

  // request decode: shift command, status and read value
  always_comb begin
    ctrl     = '0;
    want_ins = 1'b0;
    rd_d     = '0;
    status_d = ST_BAD_POS;
    case (ilid_func_e'(func_i))
      FN_GET: begin
        if (in_range) begin
          rd_d     = read_data;
          status_d = ST_DONE;
        end else begin
          rd_d     = '1;
        end
      end
      FN_INS_HEAD: begin
        want_ins = 1'b1;
      end
      FN_INS_TAIL: begin
        want_ins = 1'b1;
      end
      FN_INS_POS: begin
        if (!(!pos_neg && (pos_mag > cnt_ext))) begin
          want_ins = 1'b1;
        end
      end
      FN_DEL_POS: begin
        if (in_range) begin
          ctrl.shift_down = accept;
          status_d        = ST_DONE;
        end
      end
      default: begin
        status_d = ST_BAD_POS;
      end
    endcase
    // insert into a full list is dropped
    if (want_ins) begin
      if (full) begin
        status_d = ST_FULL;
      end else begin
        ctrl.shift_up = accept;
        status_d      = ST_DONE;
      end
    end
  end

  // entry count update
  always_comb begin
    count_d = count_q;
    if (ctrl.shift_up) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.shift_down) begin
      count_d = count_q - CntW'(1);
    end
  end

  // row of cells, each handing its entry to its neighbors
  for (genvar g = 0; g < Capacity; g++) begin : g_cell
    logic [DATA_W-1:0] left_v, right_v;
    if (g == 0) begin : g_first
      assign left_v = value_i;
    end else begin : g_mid_l
      assign left_v = cell_val[g-1];
    end
    if (g == Capacity - 1) begin : g_last
      assign right_v = cell_val[g];
    end else begin : g_mid_r
      assign right_v = cell_val[g+1];
    end
    ilid_cell #(
      .Idx  (g),
      .PosW (CmpW)
    ) u_cell (
      .clk_i         (clk_i),
      .ctrl_i        (ctrl),
      .op_pos_i      (op_pos),
      .new_value_i   (value_i),
      .left_value_i  (left_v),
      .right_value_i (right_v),
      .value_o       (cell_val[g]),
      .read_value_o  (cell_rd[g])
    );
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // result payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rd_q     <= rd_d;
      status_q <= status_d;
      item_q   <= ITEM_W'(count_d);
    end
  end

  assign done_o       = done_q;
  assign read_value_o = rd_q;
  assign status_o     = status_q;
  assign item_count_o = item_q;

  // checks
  `ILID_ASSERT_IMP(a_count_bound, 1'b1, count_q <= CapCnt, "count above capacity")
  `ILID_ASSERT_NXT(a_done_follows, accept, done_o, "no result after request")
  `ILID_ASSERT_NXT(a_full_hold, accept && want_ins && full, $stable(count_q) && status_o == ST_FULL, "full insert changed list")
  `ILID_ASSERT_NXT(a_del_count, ctrl.shift_down, count_q + CntW'(1) == $past(count_q), "delete count wrong")
  `ILID_ASSERT_IMP(a_status_code, done_o, status_o == ST_DONE || status_o == ST_BAD_POS || status_o == ST_FULL, "bad status code")

endmodule

// File: sim/tb.sv
// self-checking testbench for indexed_list_insert_delete_core: list requests with random gaps
// depends on ilid_pkg and the indexed_list_insert_delete_core rtl
`timescale 1ns / 1ps

module tb;
  import ilid_pkg::*;

  localparam int unsigned RAND_ITEMS  = 1250;
  localparam int unsigned TAIL_NO_GAP = 150;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned SETTLE      = 6;

  // one list request as the driver presents it
  typedef struct {
    logic [FUNC_W-1:0]        func;
    logic signed [POS_W-1:0]  pos;
    logic signed [DATA_W-1:0] value;
    bit                       drain;   // hold off until every result is back
    bit                       gap_ok;  // idle bursts allowed before this request
  } list_req_t;

  // one list result
  typedef struct {
    logic signed [DATA_W-1:0] read_value;
    logic [STAT_W-1:0]        status;
    logic [ITEM_W-1:0]        item_count;
  } list_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     start_i = 1'b0;
  logic                     busy_o;
  logic [FUNC_W-1:0]        func_i = FN_GET;
  logic signed [POS_W-1:0]  position_i = '0;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     done_o;
  logic signed [DATA_W-1:0] read_value_o;
  logic [STAT_W-1:0]        status_o;
  logic [ITEM_W-1:0]        item_count_o;

  list_req_t                req_pending[$];
  list_result_t             results_due[$];
  logic signed [DATA_W-1:0] list_entries[$];
  int unsigned              gen_len;
  int unsigned              gap_left;
  int unsigned              cycle_cnt;
  int unsigned              fail_cnt;

  indexed_list_insert_delete_core u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .func_i       (func_i),
    .position_i   (position_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .read_value_o (read_value_o),
    .status_o     (status_o),
    .item_count_o (item_count_o)
  );

  // clock, 8 ns period
  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // list behavior: applies one request to the local copy and returns its result
  function automatic list_result_t apply_request(logic [FUNC_W-1:0] func,
      logic signed [POS_W-1:0] pos, logic signed [DATA_W-1:0] value);
    list_result_t res;
    int           p;
    int           len;
    bit           hit;
    bit           full;
    p    = pos;
    len  = list_entries.size();
    hit  = (p >= 0) && (p < len);
    full = (len >= CAPACITY_DEF);
    res.read_value = '0;
    res.status     = ST_BAD_POS;
    case (func)
      FN_GET: begin
        if (hit) begin
          res.read_value = list_entries[p];
          res.status     = ST_DONE;
        end else begin
          res.read_value = -1;
        end
      end
      FN_INS_HEAD: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          list_entries.push_front(value);
          res.status = ST_DONE;
        end
      end
      FN_INS_TAIL: begin
        if (full) begin
          res.status = ST_FULL;
        end else begin
          list_entries.push_back(value);
          res.status = ST_DONE;
        end
      end
      FN_INS_POS: begin
        // beyond-end check wins over the full check
        if (p > len) begin
          res.status = ST_BAD_POS;
        end else if (full) begin
          res.status = ST_FULL;
        end else begin
          list_entries.insert((p < 0) ? 0 : p, value);
          res.status = ST_DONE;
        end
      end
      FN_DEL_POS: begin
        if (hit) begin
          list_entries.delete(p);
          res.status = ST_DONE;
        end
      end
      default: res.status = ST_BAD_POS;
    endcase
    res.item_count = ITEM_W'(list_entries.size());
    return res;
  endfunction

  // queue a request and track the list length it leaves behind
  task automatic push_req(logic [FUNC_W-1:0] func, int pos, logic signed [DATA_W-1:0] value,
      bit drain, bit gap_ok);
    list_req_t r;
    int        p;
    r.func   = func;
    r.pos    = POS_W'(pos);
    r.value  = value;
    r.drain  = drain;
    r.gap_ok = gap_ok;
    req_pending.push_back(r);
    p = r.pos;
    case (func)
      FN_INS_HEAD, FN_INS_TAIL: if (gen_len < CAPACITY_DEF) gen_len++;
      FN_INS_POS: if (p <= int'(gen_len) && gen_len < CAPACITY_DEF) gen_len++;
      FN_DEL_POS: if (p >= 0 && p < int'(gen_len)) gen_len--;
      default: ;
    endcase
  endtask

  // random data word, with the extremes now and then
  function automatic logic signed [DATA_W-1:0] pick_value();
    logic signed [DATA_W-1:0] v;
    case ($urandom_range(0, 39))
      0: v = '0;
      1: v = -1;
      2: v = {1'b0, {(DATA_W-1){1'b1}}};
      3: v = {1'b1, {(DATA_W-1){1'b0}}};
      default: v = $urandom;
    endcase
    return v;
  endfunction

  // position: mostly inside the list, sometimes any 8-bit code
  function automatic int pick_pos(int unsigned span);
    if ($urandom_range(0, 99) < 85) return $urandom_range(0, span);
    return $urandom_range(0, 255);
  endfunction

  // request driver, changes inputs on the falling edge
  always @(negedge clk_i) begin
    bit go;
    go = 1'b0;
    if (!rst_ni) begin
      go = 1'b0;
    end else if (gap_left != 0) begin
      gap_left--;
    end else if (req_pending.size() == 0) begin
      go = 1'b0;
    end else if (req_pending[0].drain && results_due.size() != 0) begin
      go = 1'b0;
    end else if (req_pending[0].gap_ok && req_pending.size() > TAIL_NO_GAP &&
                 $urandom_range(0, 5) == 0) begin
      gap_left = $urandom_range(1, 13) - 1;
    end else begin
      go = 1'b1;
    end
    start_i <= go;
    if (go) begin
      func_i     <= req_pending[0].func;
      position_i <= req_pending[0].pos;
      value_i    <= req_pending[0].value;
    end
  end

  // result check, then request acceptance, on the rising edge
  always @(posedge clk_i) begin
    list_result_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (results_due.size() == 0) begin
          $error("result with no request outstanding: read_value %0d status %0d count %0d",
                 read_value_o, status_o, item_count_o);
          fail_cnt++;
        end else begin
          want = results_due.pop_front();
          if (read_value_o !== want.read_value) begin
            $error("read_value mismatch: expected %0d, got %0d", want.read_value,
                   read_value_o);
            fail_cnt++;
          end
          if (status_o !== want.status) begin
            $error("status mismatch: expected %0d, got %0d", want.status, status_o);
            fail_cnt++;
          end
          if (item_count_o !== want.item_count) begin
            $error("item_count mismatch: expected %0d, got %0d", want.item_count,
                   item_count_o);
            fail_cnt++;
          end
        end
      end
      if (start_i && !busy_o) begin
        results_due.push_back(apply_request(func_i, position_i, value_i));
        req_pending.delete(0);
      end
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("indexed_list_insert_delete_core regression: fail");
      $finish;
    end
  end

  // stimulus, reset and end of run
  initial begin
    int unsigned n_rand;
    int unsigned span;
    int unsigned mode;
    int unsigned roll;
    int unsigned k;
    bit          gap_ok;
    bit          drain;
    logic [FUNC_W-1:0] f;
    int          p;
    gen_len   = 0;
    gap_left  = 0;
    cycle_cnt = 0;
    fail_cnt  = 0;

    // directed: empty list, every operation, edge positions and values
    push_req(FN_GET, 0, pick_value(), 1'b0, 1'b1);
    push_req(FN_DEL_POS, 0, pick_value(), 1'b0, 1'b1);
    push_req(FN_INS_POS, 1, 32'sh1234_5678, 1'b0, 1'b1);        // beyond end of empty list
    push_req(FN_INS_POS, 0, {1'b0, {(DATA_W-1){1'b1}}}, 1'b0, 1'b1);
    push_req(FN_INS_HEAD, 0, {1'b1, {(DATA_W-1){1'b0}}}, 1'b0, 1'b1);
    push_req(FN_INS_TAIL, 0, '0, 1'b0, 1'b1);
    push_req(FN_INS_POS, -128, -1, 1'b0, 1'b1);                 // negative acts as head
    push_req(FN_INS_POS, 4, 32'sh5555_5555, 1'b0, 1'b1);        // equal to count appends
    push_req(FN_INS_POS, 127, 32'shAAAA_AAAA, 1'b0, 1'b1);      // beyond end
    push_req(FN_GET, 0, '0, 1'b0, 1'b1);
    push_req(FN_GET, 4, '0, 1'b0, 1'b1);
    push_req(FN_GET, 5, '0, 1'b0, 1'b1);
    push_req(FN_GET, -1, '0, 1'b0, 1'b1);
    push_req(FN_GET, 127, '0, 1'b0, 1'b1);
    push_req(FN_GET, -128, '0, 1'b0, 1'b1);
    push_req(FN_DEL_POS, -1, '0, 1'b0, 1'b1);
    push_req(FN_DEL_POS, 5, '0, 1'b0, 1'b1);
    push_req(FN_DEL_POS, 4, '0, 1'b0, 1'b1);
    push_req(FN_DEL_POS, 0, '0, 1'b0, 1'b1);
    push_req(FN_INS_POS, 2, 32'shAAAA_AAAA, 1'b0, 1'b1);
    push_req(FN_DEL_POS + FUNC_W'(1), 1, pick_value(), 1'b0, 1'b1);
    push_req(FN_DEL_POS + FUNC_W'(2), 0, pick_value(), 1'b0, 1'b1);
    push_req(FN_DEL_POS + FUNC_W'(3), -1, pick_value(), 1'b0, 1'b1);
    push_req(FN_GET, 1, '0, 1'b0, 1'b1);

    // random phases: growing, shrinking and mixed, gaps on or off per phase
    n_rand = 0;
    while (n_rand < RAND_ITEMS) begin
      mode   = (n_rand == 0) ? 0 : $urandom_range(0, 2);
      span   = $urandom_range(40, 120);
      gap_ok = ($urandom_range(0, 3) != 0);
      for (k = 0; k < span; k++) begin
        roll = $urandom_range(0, 99);
        if (roll >= 97) begin
          f = FN_DEL_POS + FUNC_W'($urandom_range(1, 3));
        end else if (roll < ((mode == 0) ? 80 : (mode == 1) ? 20 : 40)) begin
          case ($urandom_range(0, 2))
            0: f = FN_INS_HEAD;
            1: f = FN_INS_TAIL;
            default: f = FN_INS_POS;
          endcase
        end else if (roll < ((mode == 0) ? 90 : (mode == 1) ? 40 : 70)) begin
          f = FN_GET;
        end else begin
          f = FN_DEL_POS;
        end
        if (f == FN_INS_POS) p = pick_pos(gen_len);
        else p = pick_pos((gen_len == 0) ? 0 : gen_len - 1);
        drain = (n_rand == 0) || (k == 0 && $urandom_range(0, 2) == 0);
        push_req(f, p, pick_value(), drain, gap_ok);
        n_rand++;
      end
    end

    // reset, released on a falling edge
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain everything, then let the block settle before the verdict
    while (req_pending.size() != 0 || results_due.size() != 0) @(negedge clk_i);
    repeat (SETTLE) @(negedge clk_i);
    if (fail_cnt == 0) begin
      $display("indexed_list_insert_delete_core regression: pass");
    end else begin
      $display("indexed_list_insert_delete_core regression: fail");
    end
    $finish;
  end

endmodule
